// ===== src/skct_pkg.sv =====
// Package for the sorted key counter table: sizes, codes and controller/datapath types.
`timescale 1ns / 1ps
`default_nettype none

package skct_pkg;

  localparam int TABLE_ENTRIES = 16;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 16;
  localparam int COUNT_W = 31;

  // fill count holds 0..TABLE_ENTRIES, entry index holds 0..TABLE_ENTRIES-1
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int IN_TDATA_W  = ((KEY_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((COUNT_W + 2 + 7) / 8) * 8;

  localparam logic [CNT_W-1:0]   TABLE_FULL = CNT_W'(TABLE_ENTRIES);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_INC = 2'd0,
    KIND_DEC = 2'd1,
    KIND_SET = 2'd2,
    KIND_GET = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic capture;  // take the incoming word into the request register
    logic search;   // register lookup position, hit and current count
    logic commit;   // apply the update and load the output register
  } cmd_t;

  typedef struct packed {
    logic             out_stall;  // output register full and not taken
    logic [CNT_W-1:0] used;       // entries in use
  } status_t;

endpackage

`default_nettype wire

// ===== src/sorted_key_counter_table.sv =====
// Top level of the sorted key counter table.
`timescale 1ns / 1ps
`default_nettype none

// Table of up to TABLE_ENTRIES counters kept in ascending key order. Each input word
// (kind in tuser; key and amount in tdata) yields one result word holding the count
// after the operation, whether the key was already present, and whether a needed
// insert was refused because the table was full. A search state compares the key
// against all valid entries in parallel and picks the lowest entry not below it; an
// update state then applies the update, shifts the tail up for an insert and loads
// the output register. A new word is taken in that update cycle, so the next word is
// captured while the last one is updated; a result left waiting at the output holds
// the update of the following word until it is taken. The fill count clears at reset;
// entry contents need no clearing, so the block is ready right after reset.
module sorted_key_counter_table
  import skct_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [15:0] key, [46:16] amount, [47] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [KIND_W-1:0]      s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [30:0] count, [31] found, [32] full_res, [39:33] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  cmd_t    cmd;
  status_t status;

  skct_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  skct_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.used <= TABLE_FULL)
    else $error("fill count beyond table size");

  a_used_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> status.used >= $past(status.used))
    else $error("fill count decreased");

  a_search_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o && cmd.search)
    else $error("accepted word not followed by a search cycle");

  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[COUNT_W] && m_axis_tdata_o[COUNT_W+1]))
    else $error("result flags both found and full");

endmodule

`default_nettype wire

// ===== src/skct_ctrl.sv =====
// Controller for the sorted key counter table: search / update sequencing.
`timescale 1ns / 1ps
`default_nettype none

module skct_ctrl
  import skct_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   commit_ok;
  logic   accept;

  assign commit_ok = (state_q == ST_UPDATE) && !status_i.out_stall;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit_ok) state_d = accept ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a new word may enter in the update cycle; its search sees the committed table
  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
      end
      ST_UPDATE: begin
        s_axis_tready_o = commit_ok;
        cmd_o.commit    = commit_ok;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
    cmd_o.capture = s_axis_tvalid_i && s_axis_tready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/skct_datapath.sv =====
// Datapath for the sorted key counter table: entry registers, lookup, update, output register.
`timescale 1ns / 1ps
`default_nettype none

module skct_datapath
  import skct_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output status_t                     status_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic [KIND_W-1:0]      s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  logic [KEY_W-1:0]   key_q [TABLE_ENTRIES];
  logic [COUNT_W-1:0] cnt_q [TABLE_ENTRIES];
  logic [CNT_W-1:0]   used_q, used_d;

  kind_e              req_kind_q;
  logic [KEY_W-1:0]   req_key_q;
  logic [COUNT_W-1:0] req_amt_q;

  logic [CNT_W-1:0]   pos_d, pos_q;
  logic               hit_d, hit_q;
  logic [COUNT_W-1:0] cur_d, cur_q;
  logic [IDX_W-1:0]   pos_idx;

  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] upd_cnt;
  logic               need_ins;
  logic               ins_ok;
  logic               full_d;
  logic [COUNT_W-1:0] res_cnt;

  logic               out_valid_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic               out_found_q;
  logic               out_full_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_kind_q <= kind_e'(s_axis_tuser_i);
      req_key_q  <= s_axis_tdata_i[KEY_W-1:0];
      req_amt_q  <= s_axis_tdata_i[KEY_W+COUNT_W-1:KEY_W];
    end
  end

  // parallel compare over valid entries; descending scan leaves the lowest key >= request
  always_comb begin
    pos_d = used_q;
    hit_d = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < used_q) && (key_q[i] >= req_key_q)) pos_d = CNT_W'(i);
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if ((CNT_W'(i) < used_q) && (key_q[i] == req_key_q)) hit_d = 1'b1;
    end
    cur_d = cnt_q[pos_d[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      pos_q <= pos_d;
      hit_q <= hit_d;
      cur_q <= cur_d;
    end
  end

  assign pos_idx = pos_q[IDX_W-1:0];

  // both operands below 2^31, so the carry bit alone flags saturation
  assign sum = {1'b0, cur_q} + {1'b0, req_amt_q};

  always_comb begin
    unique case (req_kind_q)
      KIND_INC: upd_cnt = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      KIND_DEC: upd_cnt = (cur_q > req_amt_q) ? (cur_q - req_amt_q) : '0;
      KIND_SET: upd_cnt = req_amt_q;
      KIND_GET: upd_cnt = cur_q;
      default:  upd_cnt = cur_q;
    endcase
  end

  assign need_ins = !hit_q && ((req_kind_q == KIND_INC) || (req_kind_q == KIND_SET));
  assign ins_ok   = need_ins && (used_q != TABLE_FULL);
  assign full_d   = need_ins && (used_q == TABLE_FULL);
  assign res_cnt  = hit_q ? upd_cnt : (ins_ok ? req_amt_q : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (hit_q) begin
        cnt_q[pos_idx] <= upd_cnt;
      end else if (ins_ok) begin
        // open a slot at the insert position by moving the tail up one entry
        for (int i = TABLE_ENTRIES - 1; i >= 1; i--) begin
          if ((CNT_W'(i) > pos_q) && (CNT_W'(i) <= used_q)) begin
            key_q[i] <= key_q[i-1];
            cnt_q[i] <= cnt_q[i-1];
          end
        end
        key_q[pos_idx] <= req_key_q;
        cnt_q[pos_idx] <= req_amt_q;
      end
    end
  end

  assign used_d = (cmd_i.commit && ins_ok) ? used_q + CNT_W'(1) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q <= used_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_cnt_q   <= res_cnt;
      out_found_q <= hit_q;
      out_full_q  <= full_d;
    end
  end

  assign status_o.out_stall = out_valid_q && !m_axis_tready_i;
  assign status_o.used      = used_q;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - COUNT_W - 2){1'b0}}, out_full_q, out_found_q,
                            out_cnt_q};

endmodule

`default_nettype wire
